// ===== design/s2dec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package s2dec_pkg;

   localparam int VALUE_BITS_DEF = 32;

   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   // decimal digits needed for the largest magnitude, 2**(bits-1)
   function automatic int dec_digits(input int bits);
      longint unsigned v;
      int n;
      v = 64'd1 << (bits - 1);
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (v != 0) begin
            v = v / 10;
            n = n + 1;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== design/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Converts one signed two's-complement value per start pulse into its decimal
// text, sent as a run of character words on rsp_valid strobes: '-' first for a
// negative value, then the digits most significant first with no leading zeros,
// rsp_last high on the final digit. The receiver cannot stall: every word is on
// the rsp_ ports for exactly one cycle and must be taken then. After accept, busy
// stays high until the last digit position has been shifted out, and the next
// value can be accepted once busy drops; start is ignored while busy. Conversion is
// one shift-and-add-3 step per input bit on a shared BCD register of D digits
// (D = decimal digits of 2**(VALUE_BITS-1), 10 at the default width), then one
// digit position at a time as the BCD register shifts out, leading zeros being
// skipped silently. The minus sign goes out in the first conversion cycle.
module signed_int_to_decimal_ascii_core
   import s2dec_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output logic                              rsp_valid,
   output logic             [7:0]            rsp_character,
   output logic                              rsp_last
);

   localparam int NDIG = dec_digits(VALUE_BITS);
   localparam int BCDW = 4 * NDIG;
   localparam int CW   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DW   = (NDIG > 1) ? $clog2(NDIG) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [VALUE_BITS-1:0]   bin_ff;
   logic [BCDW-1:0]         bcd_ff;
   logic [CW-1:0]           cnt_ff;
   logic [DW-1:0]           dig_ff;
   logic                    started_ff;
   logic                    valid_ff;
   logic [7:0]              char_ff;
   logic                    last_ff;

   logic [VALUE_BITS-1:0]   mag_in;
   logic [BCDW-1:0]         bcd_adj;
   logic [3:0]              top_digit;
   logic                    last_pos;

   assign mag_in = req_value[VALUE_BITS-1] ? VALUE_BITS'(~$unsigned(req_value) + 1'b1)
                                           : $unsigned(req_value);

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCDW-1 -: 4];
   assign last_pos  = (dig_ff == DW'(NDIG - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         cnt_ff     <= '0;
         dig_ff     <= '0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  bin_ff   <= mag_in;
                  bcd_ff   <= '0;
                  cnt_ff   <= '0;
                  valid_ff <= req_value[VALUE_BITS-1];
                  char_ff  <= CHAR_MINUS;
                  last_ff  <= 1'b0;
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               bcd_ff <= {bcd_adj[BCDW-2:0], bin_ff[VALUE_BITS-1]};
               bin_ff <= {bin_ff[VALUE_BITS-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(VALUE_BITS - 1)) begin
                  dig_ff     <= '0;
                  started_ff <= 1'b0;
                  state_ff   <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (top_digit != 4'd0 || started_ff || last_pos) begin
                  valid_ff   <= 1'b1;
                  char_ff    <= CHAR_ZERO + {4'd0, top_digit};
                  last_ff    <= last_pos;
                  started_ff <= 1'b1;
               end
               bcd_ff <= {bcd_ff[BCDW-5:0], 4'd0};
               dig_ff <= dig_ff + 1'b1;
               if (last_pos) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire
